FILE: hw/rtl/glpf_pkg.sv
package glpf_pkg;

    // Default sizes of the grid and of one sample.
    localparam int DEF_MAX_COLS     = 32;
    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_ROW_W  = 9;
    localparam int CFG_COL_W  = 6;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    // Result fields and their packing.
    localparam int ROW_OUT_W = 8;
    localparam int COL_OUT_W = 5;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - ROW_OUT_W - COL_OUT_W;

endpackage

FILE: hw/rtl/grid_local_peak_finder_top.sv
// Channel   Direction  Contents
// s_*       in         one grid sample per request, raster order
// m_*       out        row and column of one local maximum, tlast ends a burst
// cfg_*     in         register writes: row count, column count
//
// A sample is taken every clock while the output register is free or being
// emptied. A frame end with a flag set starts a scan of the last-row flags, one
// column per cycle unless a flagged one stalls, up to the highest flagged column;
// no sample is taken meanwhile. Reset is synchronous and active low; it sets a
// 2 x 2 grid. A stalled m_tready holds the output register and with it s_tready.
module grid_local_peak_finder_top #(
    parameter int MAX_COLS     = glpf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS     = glpf_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_WIDTH = glpf_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // tdata: sample_value
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: peak_row, peak_col
    output logic [glpf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glpf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [glpf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import glpf_pkg::*;

    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COL_IDX_W = $clog2(MAX_COLS);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BURST = 1'b1;

    logic                          state_reg;
    logic [ROW_IDX_W-1:0]          rows_last_reg, rows_last_next;
    logic [COL_IDX_W-1:0]          cols_last_reg, cols_last_next;
    logic [ROW_IDX_W-1:0]          row_pos_reg;
    logic [COL_IDX_W-1:0]          col_pos_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_reg, left2_reg, above_prev_reg;
    logic [MAX_COLS-1:0]           flags_reg, scan_reg;
    logic [COL_IDX_W-1:0]          scan_col_reg;
    logic [ROW_IDX_W-1:0]          burst_row_reg;
    logic                          m_valid_reg, m_last_reg;
    logic [ROW_OUT_W-1:0]          m_row_reg;
    logic [COL_OUT_W-1:0]          m_col_reg;

    logic signed [SAMPLE_WIDTH-1:0] x;
    logic signed [SAMPLE_WIDTH-1:0] a_head, a_next, b_head, b_unused;
    logic                          accept, out_free, cfg_write;
    logic                          last_row, last_col, frame_end;
    logic                          above_pk, above_valid, left_pk, self_pk;
    logic [MAX_COLS-1:0]           flag_set, flags_all;
    logic                          burst_start;
    logic                          scan_go, scan_emit;
    logic [MAX_COLS-1:0]           scan_shifted;

    assign x = s_tdata[SAMPLE_WIDTH-1:0];

    // Handshakes.
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Two cell rows: line A delays by one grid row, line B by two.
    glpf_line #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line_a (
        .aclk         (aclk),
        .shift_en     (accept),
        .inject_at    (cols_last_reg),
        .din          (x),
        .head         (a_head),
        .next_to_head (a_next)
    );

    glpf_line #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line_b (
        .aclk         (aclk),
        .shift_en     (accept),
        .inject_at    (cols_last_reg),
        .din          (a_head),
        .head         (b_head),
        .next_to_head (b_unused)
    );

    // Clamp a written count into its legal range and keep it as a last index.
    always_comb begin
        logic [CFG_ROW_W-1:0] rv;
        logic [CFG_COL_W-1:0] cv;
        rv = cfg_data[CFG_ROW_W-1:0];
        cv = cfg_data[CFG_COL_W-1:0];
        if (rv < CFG_ROW_W'(2)) begin
            rows_last_next = ROW_IDX_W'(1);
        end else if (32'(rv) > 32'(MAX_ROWS)) begin
            rows_last_next = ROW_IDX_W'(MAX_ROWS - 1);
        end else begin
            rows_last_next = ROW_IDX_W'(32'(rv) - 32'd1);
        end
        if (cv < CFG_COL_W'(2)) begin
            cols_last_next = COL_IDX_W'(1);
        end else if (32'(cv) > 32'(MAX_COLS)) begin
            cols_last_next = COL_IDX_W'(MAX_COLS - 1);
        end else begin
            cols_last_next = COL_IDX_W'(32'(cv) - 32'd1);
        end
    end

    assign last_row  = (row_pos_reg == rows_last_reg);
    assign last_col  = (col_pos_reg == cols_last_reg);
    assign frame_end = last_row && last_col;

    // Decision for the sample directly above the incoming one.
    assign above_pk = (a_head >= x)
                   && ((row_pos_reg <= ROW_IDX_W'(1)) || (a_head >= b_head))
                   && ((col_pos_reg == '0) || (a_head >= above_prev_reg))
                   && (last_col || (a_head >= a_next));
    assign above_valid = (row_pos_reg != '0) && above_pk;

    // Last row: the previous sample now has its right neighbor, and the
    // final sample is decided at once.
    assign left_pk = last_row && (col_pos_reg != '0)
                  && (left_reg >= x) && (left_reg >= above_prev_reg)
                  && ((col_pos_reg <= COL_IDX_W'(1)) || (left_reg >= left2_reg));
    assign self_pk = frame_end && (x >= left_reg) && (x >= a_head);

    always_comb begin
        flag_set = '0;
        if (left_pk) begin
            flag_set = flag_set | (MAX_COLS'(1) << (col_pos_reg - COL_IDX_W'(1)));
        end
        if (self_pk) begin
            flag_set = flag_set | (MAX_COLS'(1) << col_pos_reg);
        end
    end

    assign flags_all   = flags_reg | flag_set;
    assign burst_start = frame_end && (flags_all != '0);

    // Burst scan: one column per cycle, waiting only on a flagged column.
    assign scan_go      = (state_reg == ST_BURST) && (!scan_reg[0] || out_free);
    assign scan_emit    = (state_reg == ST_BURST) && scan_reg[0] && out_free;
    assign scan_shifted = scan_reg >> 1;

    // Data path registers without reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_prev_reg <= a_head;
            left2_reg      <= left_reg;
        end
        if (accept && burst_start) begin
            scan_reg      <= flags_all;
            burst_row_reg <= row_pos_reg;
        end else if (scan_go) begin
            scan_reg <= scan_shifted;
        end
        if (accept && above_valid) begin
            m_row_reg  <= ROW_OUT_W'(32'(row_pos_reg - ROW_IDX_W'(1)));
            m_col_reg  <= COL_OUT_W'(32'(col_pos_reg));
            m_last_reg <= !burst_start;
        end else if (scan_emit) begin
            m_row_reg  <= ROW_OUT_W'(32'(burst_row_reg));
            m_col_reg  <= COL_OUT_W'(32'(scan_col_reg));
            m_last_reg <= (scan_shifted == '0);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_last_reg <= ROW_IDX_W'(1);
            cols_last_reg <= COL_IDX_W'(1);
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            left_reg      <= '0;
            flags_reg     <= '0;
            scan_col_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // Output register occupancy.
            if ((accept && above_valid) || scan_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // Frame position and last-row flags.
            if (accept) begin
                left_reg <= x;
                if (last_col) begin
                    col_pos_reg <= '0;
                    if (last_row) begin
                        row_pos_reg <= '0;
                        flags_reg   <= '0;
                    end else begin
                        row_pos_reg <= row_pos_reg + ROW_IDX_W'(1);
                    end
                end else begin
                    col_pos_reg <= col_pos_reg + COL_IDX_W'(1);
                    flags_reg   <= flags_all;
                end
            end

            // Burst sequencing.
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && burst_start) begin
                        state_reg    <= ST_BURST;
                        scan_col_reg <= '0;
                    end
                end
                ST_BURST: begin
                    if (scan_go) begin
                        scan_col_reg <= scan_col_reg + COL_IDX_W'(1);
                        if (scan_shifted == '0) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Row or column count writes restart the frame; line samples are kept.
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_ROW_COUNT: begin
                        rows_last_reg <= rows_last_next;
                        row_pos_reg   <= '0;
                        col_pos_reg   <= '0;
                        left_reg      <= '0;
                        flags_reg     <= '0;
                    end
                    REG_COL_COUNT: begin
                        cols_last_reg <= cols_last_next;
                        row_pos_reg   <= '0;
                        col_pos_reg   <= '0;
                        left_reg      <= '0;
                        flags_reg     <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_col_reg, m_row_reg};

endmodule

FILE: hw/rtl/glpf_cell.sv
module glpf_cell #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COL_IDX_W    = 5,
    parameter int CELL_INDEX   = 0
) (
    input  logic                           aclk,
    input  logic                           shift_en,
    input  logic [COL_IDX_W-1:0]           inject_at,
    input  logic signed [SAMPLE_WIDTH-1:0] din,
    input  logic signed [SAMPLE_WIDTH-1:0] from_right,
    output logic signed [SAMPLE_WIDTH-1:0] sample_q
);

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;

    // The cell at the active row end takes the new sample; all others
    // take the value of their right-hand neighbor.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            if (inject_at == COL_IDX_W'(CELL_INDEX)) begin
                sample_reg <= din;
            end else begin
                sample_reg <= from_right;
            end
        end
    end

    assign sample_q = sample_reg;

endmodule

FILE: hw/rtl/glpf_line.sv
module glpf_line #(
    parameter int MAX_COLS     = 32,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             shift_en,
    input  logic [$clog2(MAX_COLS)-1:0]      inject_at,
    input  logic signed [SAMPLE_WIDTH-1:0]   din,
    output logic signed [SAMPLE_WIDTH-1:0]   head,
    output logic signed [SAMPLE_WIDTH-1:0]   next_to_head
);

    localparam int COL_IDX_W = $clog2(MAX_COLS);

    logic signed [SAMPLE_WIDTH-1:0] cell_q [MAX_COLS];

    // A row of cells moving toward cell 0. Entering at cell cols-1, a
    // sample reaches cell 0 exactly one grid row after it arrived.
    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] right_q;

        if (k == MAX_COLS - 1) begin : g_end
            assign right_q = din;
        end else begin : g_mid
            assign right_q = cell_q[k+1];
        end

        glpf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COL_IDX_W    (COL_IDX_W),
            .CELL_INDEX   (k)
        ) u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .inject_at  (inject_at),
            .din        (din),
            .from_right (right_q),
            .sample_q   (cell_q[k])
        );
    end

    assign head         = cell_q[0];
    assign next_to_head = cell_q[1];

endmodule
